// ===== rtl/ccss_pkg.sv =====
`timescale 1ns / 1ps

package ccss_pkg;

  localparam int unsigned MAX_DELIM_DEF   = 16;
  localparam int unsigned OFFSET_BITS_DEF = 32;
  localparam int unsigned SPAN_BITS       = 32;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_EIGHT  = 8'h38;
  localparam logic [7:0] CH_UP_L   = 8'h4C;
  localparam logic [7:0] CH_UP_R   = 8'h52;
  localparam logic [7:0] CH_UP_U   = 8'h55;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LO_U   = 8'h75;

  localparam logic SPAN_COMMENT = 1'b0;
  localparam logic SPAN_STRING  = 1'b1;

  // One input item as held in the input register.
  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_of_input;
  } ccss_item_t;

  // Commands from the scanner to the raw-string delimiter matcher.
  typedef struct packed {
    logic delim_clr;
    logic delim_push;
    logic body_clr;
    logic body_push;
  } ccss_raw_ctrl_t;

  function automatic logic is_ident(input logic [7:0] b);
    return b[7] ||
           (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
           (b >= 8'h30 && b <= 8'h39) ||
           b == CH_UNDER || b == CH_DOLLAR || b == CH_BSLASH;
  endfunction

endpackage

// ===== rtl/ccss_if.sv =====
`timescale 1ns / 1ps

interface ccss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       end_of_input;

  modport source(output valid, output source_byte, output end_of_input, input ready);
  modport sink(input valid, input source_byte, input end_of_input, output ready);
endinterface

interface ccss_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] span_begin;
  logic [31:0] span_end;
  logic        span_kind;

  modport source(output valid, output span_begin, output span_end, output span_kind,
                 input ready);
  modport sink(input valid, input span_begin, input span_end, input span_kind,
               output ready);
endinterface

// ===== rtl/ccss_in_stage.sv =====
`timescale 1ns / 1ps

module ccss_in_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  ccss_pkg::ccss_item_t  item_i,
  output logic                  valid_o,
  output ccss_pkg::ccss_item_t  item_o,
  input  logic                  take_i
);
  import ccss_pkg::*;

  logic       valid_q;
  ccss_item_t item_q;

  assign ready_o = !valid_q || take_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (valid_i && ready_o) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

endmodule

// ===== rtl/ccss_raw_match.sv =====
`timescale 1ns / 1ps

module ccss_raw_match #(
  parameter int unsigned MaxDelim = ccss_pkg::MAX_DELIM_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ccss_pkg::ccss_raw_ctrl_t ctrl_i,
  input  logic [7:0]              src_byte_i,
  output logic                    close_o
);
  import ccss_pkg::*;

  localparam int unsigned LenW = $clog2(MaxDelim + 1);
  localparam int unsigned CntW = $clog2(MaxDelim + 2);

  // Delimiter kept newest first, body history newest first.
  logic [7:0]      dlm_q  [MaxDelim];
  logic [7:0]      hist_q [MaxDelim + 1];
  logic [LenW-1:0] len_q;
  logic [CntW-1:0] cnt_q;
  logic            dlm_ok;

  always_comb begin
    dlm_ok = 1'b1;
    for (int j = 0; j < MaxDelim; j++) begin
      if (LenW'(j) < len_q && hist_q[j] != dlm_q[j]) begin
        dlm_ok = 1'b0;
      end
    end
  end

  assign close_o = (cnt_q >= CntW'(len_q) + CntW'(1)) && src_byte_i == CH_DQUOTE &&
                   hist_q[len_q] == CH_RPAREN && dlm_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      cnt_q <= '0;
    end else begin
      if (ctrl_i.delim_clr) begin
        len_q <= '0;
      end else if (ctrl_i.delim_push && len_q < LenW'(MaxDelim)) begin
        len_q <= len_q + LenW'(1);
      end
      if (ctrl_i.body_clr) begin
        cnt_q <= '0;
      end else if (ctrl_i.body_push && cnt_q < CntW'(MaxDelim + 1)) begin
        cnt_q <= cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!ctrl_i.delim_clr && ctrl_i.delim_push && len_q < LenW'(MaxDelim)) begin
      dlm_q[0] <= src_byte_i;
      for (int j = 1; j < MaxDelim; j++) begin
        dlm_q[j] <= dlm_q[j-1];
      end
    end
    if (!ctrl_i.body_clr && ctrl_i.body_push) begin
      hist_q[0] <= src_byte_i;
      for (int j = 1; j < MaxDelim + 1; j++) begin
        hist_q[j] <= hist_q[j-1];
      end
    end
  end

endmodule

// ===== rtl/ccss_scan_core.sv =====
`timescale 1ns / 1ps

module ccss_scan_core #(
  parameter int unsigned OffsetBits = ccss_pkg::OFFSET_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     item_valid_i,
  input  ccss_pkg::ccss_item_t     item_i,
  output logic                     take_o,
  input  logic                     raw_close_i,
  output ccss_pkg::ccss_raw_ctrl_t raw_ctrl_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [31:0]              span_begin_o,
  output logic [31:0]              span_end_o,
  output logic                     span_kind_o
);
  import ccss_pkg::*;

  typedef enum logic [3:0] {
    M_IDLE, M_ELIG, M_SLASH, M_PFX, M_PFX_U, M_RPFX, M_STR, M_STR_ESC,
    M_LINE, M_BLOCK, M_BLOCK_STAR, M_RAW_DELIM, M_RAW_BODY
  } mode_e;

  localparam logic [OffsetBits-1:0] OffMax   = '1;
  localparam logic [OffsetBits-1:0] SpanCeil = OffsetBits'(33'h0_FFFF_FFFF);

  mode_e                 mode_q, mode_d;
  logic [OffsetBits-1:0] off_q, off_d, open_q, open_d, pend_q, pend_d, off_inc;
  logic                  out_valid_q;
  logic [31:0]           begin_q, end_q;
  logic                  kind_q;
  logic                  emit, emit_kind, emit_inc, do_idle;
  logic [OffsetBits-1:0] emit_end;
  logic [7:0]            b;

  function automatic logic [31:0] clamp_span(input logic [OffsetBits-1:0] v);
    return (v > SpanCeil) ? 32'hFFFF_FFFF : 32'(v);
  endfunction

  assign b       = item_i.source_byte;
  assign take_o  = item_valid_i && (!out_valid_q || out_ready_i);
  assign off_inc = (off_q == OffMax) ? off_q : off_q + OffsetBits'(1);

  always_comb begin
    mode_d     = mode_q;
    off_d      = off_inc;
    open_d     = open_q;
    pend_d     = pend_q;
    emit       = 1'b0;
    emit_kind  = SPAN_COMMENT;
    emit_inc   = 1'b0;
    do_idle    = 1'b0;
    raw_ctrl_o = '0;

    if (item_i.end_of_input) begin
      unique case (mode_q)
        M_LINE, M_BLOCK, M_BLOCK_STAR: begin
          emit = 1'b1;
        end
        M_STR, M_STR_ESC, M_RAW_DELIM, M_RAW_BODY: begin
          emit      = 1'b1;
          emit_kind = SPAN_STRING;
        end
        default: ;
      endcase
      // Return to the start-of-file state.
      mode_d              = M_ELIG;
      off_d               = '0;
      open_d              = '0;
      pend_d              = '0;
      raw_ctrl_o.delim_clr = 1'b1;
      raw_ctrl_o.body_clr  = 1'b1;
    end else begin
      unique case (mode_q)
        M_ELIG: begin
          if (b == CH_UP_L || b == CH_UP_U) begin
            pend_d = off_q;
            mode_d = M_PFX;
          end else if (b == CH_LO_U) begin
            pend_d = off_q;
            mode_d = M_PFX_U;
          end else if (b == CH_UP_R) begin
            pend_d = off_q;
            mode_d = M_RPFX;
          end else begin
            do_idle = 1'b1;
          end
        end
        M_PFX, M_PFX_U: begin
          if (mode_q == M_PFX_U && b == CH_EIGHT) begin
            mode_d = M_PFX;
          end else if (b == CH_DQUOTE) begin
            open_d = pend_q;
            mode_d = M_STR;
          end else if (b == CH_UP_R) begin
            mode_d = M_RPFX;
          end else begin
            do_idle = 1'b1;
          end
        end
        M_RPFX: begin
          if (b == CH_DQUOTE) begin
            open_d               = pend_q;
            raw_ctrl_o.delim_clr = 1'b1;
            mode_d               = M_RAW_DELIM;
          end else begin
            do_idle = 1'b1;
          end
        end
        M_SLASH: begin
          if (b == CH_SLASH) begin
            open_d = pend_q;
            mode_d = M_LINE;
          end else if (b == CH_STAR) begin
            open_d = pend_q;
            mode_d = M_BLOCK;
          end else begin
            do_idle = 1'b1;
          end
        end
        M_LINE: begin
          if (b == CH_NL) begin
            emit    = 1'b1;
            do_idle = 1'b1;
          end
        end
        M_BLOCK: begin
          if (b == CH_STAR) begin
            mode_d = M_BLOCK_STAR;
          end
        end
        M_BLOCK_STAR: begin
          if (b == CH_SLASH) begin
            emit     = 1'b1;
            emit_inc = 1'b1;
            mode_d   = M_IDLE;
          end else if (b != CH_STAR) begin
            mode_d = M_BLOCK;
          end
        end
        M_STR: begin
          if (b == CH_BSLASH) begin
            mode_d = M_STR_ESC;
          end else if (b == CH_DQUOTE) begin
            emit      = 1'b1;
            emit_inc  = 1'b1;
            emit_kind = SPAN_STRING;
            mode_d    = M_IDLE;
          end
        end
        M_STR_ESC: begin
          mode_d = M_STR;
        end
        M_RAW_DELIM: begin
          if (b == CH_LPAREN) begin
            raw_ctrl_o.body_clr = 1'b1;
            mode_d              = M_RAW_BODY;
          end else begin
            raw_ctrl_o.delim_push = 1'b1;
          end
        end
        M_RAW_BODY: begin
          raw_ctrl_o.body_push = 1'b1;
          if (raw_close_i) begin
            emit      = 1'b1;
            emit_inc  = 1'b1;
            emit_kind = SPAN_STRING;
            mode_d    = M_IDLE;
          end
        end
        default: begin
          do_idle = 1'b1;
        end
      endcase

      // Ordinary byte outside any span.
      if (do_idle) begin
        if (b == CH_SLASH) begin
          pend_d = off_q;
          mode_d = M_SLASH;
        end else if (b == CH_DQUOTE) begin
          open_d = off_q;
          mode_d = M_STR;
        end else if (is_ident(b)) begin
          mode_d = M_IDLE;
        end else begin
          mode_d = M_ELIG;
        end
      end
    end

    emit_end = emit_inc ? off_inc : off_q;

    // Drop all commands unless the item is actually consumed this cycle.
    if (!take_o) begin
      raw_ctrl_o = '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign span_begin_o = begin_q;
  assign span_end_o   = end_q;
  assign span_kind_o  = kind_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= M_ELIG;
      off_q       <= '0;
      open_q      <= '0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take_o) begin
        mode_q      <= mode_d;
        off_q       <= off_d;
        open_q      <= open_d;
        pend_q      <= pend_d;
        out_valid_q <= emit;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && emit) begin
      begin_q <= clamp_span(open_q);
      end_q   <= clamp_span(emit_end);
      kind_q  <= emit_kind;
    end
  end

endmodule

// ===== rtl/cpp_comment_string_span_scanner.sv =====
`timescale 1ns / 1ps
// Path: the byte that closes a span passes through the input register and then the
//   result register before that span can be transferred on out_o.
// Throughput: one byte per cycle while no result waits with out_o.ready low, set by the mode update in the scanner.
// Reset: rst_ni clears all control state at once; no clearing pass is needed.

module cpp_comment_string_span_scanner #(
  parameter int unsigned MaxDelim   = ccss_pkg::MAX_DELIM_DEF,
  parameter int unsigned OffsetBits = ccss_pkg::OFFSET_BITS_DEF
) (
  input logic            clk_i,
  input logic            rst_ni,
  ccss_in_if.sink        in_i,
  ccss_out_if.source     out_o
);
  import ccss_pkg::*;

  // Input register handshake: it takes a new transfer whenever it is empty or the
  // scanner consumes its current item in the same cycle.
  ccss_item_t     in_item, held_item;
  logic           held_valid;
  logic           take;
  ccss_raw_ctrl_t raw_ctrl;
  logic           raw_close;

  assign in_item.source_byte  = in_i.source_byte;
  assign in_item.end_of_input = in_i.end_of_input;

  ccss_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .item_i  (in_item),
    .valid_o (held_valid),
    .item_o  (held_item),
    .take_i  (take)
  );

  // Raw-string closing detector: compares the latest body bytes against the stored
  // delimiter in parallel, so a raw string closes on the byte of its final quote.
  ccss_raw_match #(
    .MaxDelim (MaxDelim)
  ) u_raw_match (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (raw_ctrl),
    .src_byte_i (held_item.source_byte),
    .close_o    (raw_close)
  );

  // Scanner: mode machine, saturating offset counter and the result register that
  // drives the output transfer. It advances whenever the result slot is free or being
  // drained, so intake stalls only while a result waits with out_o.ready low.
  ccss_scan_core #(
    .OffsetBits (OffsetBits)
  ) u_scan_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (held_valid),
    .item_i       (held_item),
    .take_o       (take),
    .raw_close_i  (raw_close),
    .raw_ctrl_o   (raw_ctrl),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .span_begin_o (out_o.span_begin),
    .span_end_o   (out_o.span_end),
    .span_kind_o  (out_o.span_kind)
  );

endmodule

// ===== rtl/ccss_checker.sv =====
`timescale 1ns / 1ps

module ccss_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] span_begin_i,
  input logic [31:0] span_end_i,
  input logic        span_kind_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(span_begin_i) && $stable(span_end_i) && $stable(span_kind_i))
    else $error("result changed while stalled");

  a_span_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> span_end_i >= span_begin_i)
    else $error("span ends before it begins");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i && $past(out_valid_i && !out_ready_i) &&
      $past(in_valid_i && in_ready_i) |-> !in_ready_i)
    else $error("intake open with full input register and stalled result");

endmodule

bind cpp_comment_string_span_scanner ccss_checker u_ccss_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .span_begin_i (out_o.span_begin),
  .span_end_i   (out_o.span_end),
  .span_kind_i  (out_o.span_kind)
);

// ===== test/ccss_span_checker.sv =====
`timescale 1ns / 1ps

module ccss_span_checker import ccss_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ccss_in_if          in_mon,
  ccss_out_if         out_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned predicted_o,
  output int unsigned comments_o,
  output int unsigned strings_o
);

  localparam int unsigned DELIM_MAX = MAX_DELIM_DEF;
  localparam int unsigned TAIL_LEN  = DELIM_MAX + 2;
  localparam int unsigned MAX_SHOWN = 40;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ELIG, ST_SLASH, ST_PFX, ST_PFX_U, ST_RPFX, ST_STR, ST_STR_ESC,
    ST_LINE, ST_BLOCK, ST_BLOCK_STAR, ST_RAW_DELIM, ST_RAW_BODY
  } lex_state_e;

  typedef struct packed {
    logic [31:0] first;
    logic [31:0] past;
    logic        kind;
  } span_t;

  lex_state_e  lex_state;
  logic [31:0] cur_offset;
  logic [31:0] span_open_at;
  logic [31:0] prefix_at;
  logic [7:0]  delim_buf [DELIM_MAX];
  int unsigned delim_len;
  logic [7:0]  tail_buf [TAIL_LEN];
  int unsigned tail_fill;

  span_t       spans_due [$];
  span_t       want;
  int unsigned mismatches;
  int unsigned predicted;
  int unsigned n_comment;
  int unsigned n_string;

  function automatic logic [31:0] offset_inc(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic logic ident_byte(input logic [7:0] b);
    return b[7] || (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
           (b >= "0" && b <= "9") || b == CH_UNDER || b == CH_DOLLAR || b == CH_BSLASH;
  endfunction

  function automatic void clear_scanner();
    lex_state    = ST_ELIG;
    cur_offset   = '0;
    span_open_at = '0;
    prefix_at    = '0;
    delim_len    = 0;
    tail_fill    = 0;
    for (int i = 0; i < DELIM_MAX; i++) delim_buf[i] = '0;
    for (int i = 0; i < TAIL_LEN; i++) tail_buf[i] = '0;
  endfunction

  // Byte seen outside any span, without prefix recognition.
  function automatic void plain_byte(input logic [7:0] b, input logic [31:0] off);
    if (b == CH_SLASH) begin
      prefix_at = off;
      lex_state = ST_SLASH;
    end else if (b == CH_DQUOTE) begin
      span_open_at = off;
      lex_state    = ST_STR;
    end else if (ident_byte(b)) begin
      lex_state = ST_IDLE;
    end else begin
      lex_state = ST_ELIG;
    end
  endfunction

  function automatic void close_span(input logic [31:0] past, input logic kind);
    span_t s;
    s.first = span_open_at;
    s.past  = past;
    s.kind  = kind;
    spans_due.insert(spans_due.size(), s);
    predicted++;
  endfunction

  function automatic logic raw_closed();
    int unsigned plen;
    int unsigned start;
    plen = delim_len + 2;
    if (tail_fill < plen) return 1'b0;
    start = TAIL_LEN - plen;
    if (tail_buf[start] != CH_RPAREN || tail_buf[TAIL_LEN-1] != CH_DQUOTE) return 1'b0;
    for (int i = 0; i < delim_len; i++)
      if (tail_buf[start+1+i] != delim_buf[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void scan_item(input logic [7:0] b, input logic eoi);
    logic [31:0] off;
    off = cur_offset;
    if (eoi) begin
      case (lex_state)
        ST_LINE, ST_BLOCK, ST_BLOCK_STAR: close_span(off, SPAN_COMMENT);
        ST_STR, ST_STR_ESC, ST_RAW_DELIM, ST_RAW_BODY: close_span(off, SPAN_STRING);
        default: ;
      endcase
      clear_scanner();
      return;
    end
    case (lex_state)
      ST_ELIG: begin
        if (b == CH_UP_L || b == CH_UP_U) begin
          prefix_at = off;
          lex_state = ST_PFX;
        end else if (b == CH_LO_U) begin
          prefix_at = off;
          lex_state = ST_PFX_U;
        end else if (b == CH_UP_R) begin
          prefix_at = off;
          lex_state = ST_RPFX;
        end else begin
          plain_byte(b, off);
        end
      end
      ST_PFX_U, ST_PFX: begin
        if (lex_state == ST_PFX_U && b == CH_EIGHT) begin
          lex_state = ST_PFX;
        end else if (b == CH_DQUOTE) begin
          span_open_at = prefix_at;
          lex_state    = ST_STR;
        end else if (b == CH_UP_R) begin
          lex_state = ST_RPFX;
        end else begin
          plain_byte(b, off);
        end
      end
      ST_RPFX: begin
        if (b == CH_DQUOTE) begin
          span_open_at = prefix_at;
          delim_len    = 0;
          lex_state    = ST_RAW_DELIM;
        end else begin
          plain_byte(b, off);
        end
      end
      ST_SLASH: begin
        if (b == CH_SLASH) begin
          span_open_at = prefix_at;
          lex_state    = ST_LINE;
        end else if (b == CH_STAR) begin
          span_open_at = prefix_at;
          lex_state    = ST_BLOCK;
        end else begin
          plain_byte(b, off);
        end
      end
      ST_LINE: begin
        if (b == CH_NL) begin
          close_span(off, SPAN_COMMENT);
          plain_byte(b, off);
        end
      end
      ST_BLOCK: begin
        if (b == CH_STAR) lex_state = ST_BLOCK_STAR;
      end
      ST_BLOCK_STAR: begin
        if (b == CH_SLASH) begin
          close_span(offset_inc(off), SPAN_COMMENT);
          lex_state = ST_IDLE;
        end else if (b != CH_STAR) begin
          lex_state = ST_BLOCK;
        end
      end
      ST_STR: begin
        if (b == CH_BSLASH) begin
          lex_state = ST_STR_ESC;
        end else if (b == CH_DQUOTE) begin
          close_span(offset_inc(off), SPAN_STRING);
          lex_state = ST_IDLE;
        end
      end
      ST_STR_ESC: lex_state = ST_STR;
      ST_RAW_DELIM: begin
        if (b == CH_LPAREN) begin
          tail_fill = 0;
          for (int i = 0; i < TAIL_LEN; i++) tail_buf[i] = '0;
          lex_state = ST_RAW_BODY;
        end else if (delim_len < DELIM_MAX) begin
          // keep only the first DELIM_MAX delimiter bytes
          delim_buf[delim_len] = b;
          delim_len++;
        end
      end
      ST_RAW_BODY: begin
        for (int i = 0; i < TAIL_LEN - 1; i++) tail_buf[i] = tail_buf[i+1];
        tail_buf[TAIL_LEN-1] = b;
        if (tail_fill < TAIL_LEN) tail_fill++;
        if (raw_closed()) begin
          close_span(offset_inc(off), SPAN_STRING);
          lex_state = ST_IDLE;
        end
      end
      default: plain_byte(b, off);
    endcase
    cur_offset = offset_inc(off);
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_SHOWN) $display("MISMATCH @%0t: %s", $time, what);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_scanner();
      spans_due.delete();
      mismatches = 0;
      predicted  = 0;
      n_comment  = 0;
      n_string   = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) scan_item(in_mon.source_byte, in_mon.end_of_input);
      if (out_mon.valid && out_mon.ready) begin
        if (spans_due.size() == 0) begin
          report_mismatch($sformatf("span [%0d,%0d) kind %0b with nothing expected",
                                    out_mon.span_begin, out_mon.span_end, out_mon.span_kind));
        end else begin
          want = spans_due.pop_front();
          if (out_mon.span_begin != want.first)
            report_mismatch($sformatf("span_begin %0d, expected %0d",
                                      out_mon.span_begin, want.first));
          if (out_mon.span_end != want.past)
            report_mismatch($sformatf("span_end %0d, expected %0d (begin %0d)",
                                      out_mon.span_end, want.past, want.first));
          if (out_mon.span_kind != want.kind)
            report_mismatch($sformatf("span_kind %0b, expected %0b (begin %0d)",
                                      out_mon.span_kind, want.kind, want.first));
          if (want.kind == SPAN_COMMENT) n_comment++;
          else n_string++;
        end
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= spans_due.size();
    predicted_o  <= predicted;
    comments_o   <= n_comment;
    strings_o    <= n_string;
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import ccss_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 600;  // stop the random part past this many items
  localparam int unsigned HOLD_CYCLES  = 400;  // long result hold-off
  localparam int unsigned MAX_GAP      = 16;
  localparam int unsigned DRAIN_LIMIT  = 5000;

  logic clk_i;
  logic rst_ni;

  ccss_in_if  in_ch ();
  ccss_out_if out_ch ();

  int unsigned fail_count;
  int unsigned pending_spans;
  int unsigned predicted_spans;
  int unsigned comment_spans;
  int unsigned string_spans;

  // Handshake between the stimulus and the result sink for the hold-off.
  bit          hold_request;
  bit          results_held;

  int unsigned bytes_sent;
  int unsigned eoi_sent;
  int unsigned tx_burst_left;
  int unsigned rx_burst_left;

  string       str_prefixes [5] = '{"", "L", "U", "u", "u8"};
  logic [7:0]  delim_bytes [20];

  cpp_comment_string_span_scanner DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  ccss_span_checker span_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending_spans),
    .predicted_o  (predicted_spans),
    .comments_o   (comment_spans),
    .strings_o    (string_spans)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("Timeout: block stopped making progress");
    $display("cpp_comment_string_span_scanner test failed");
    $finish;
  end

  // Offer one item and hold it until the transfer. Always entered and left on a rising
  // edge; a gap of zero keeps valid high across back-to-back items.
  task automatic send_item(input logic [7:0] b, input logic eoi);
    int unsigned gap;
    if (results_held) begin
      gap = 0;  // keep offering while the sink is held so the block backs up
    end else if (tx_burst_left > 0) begin
      tx_burst_left--;
      gap = 0;
    end else if ($urandom_range(0, 39) == 0) begin
      tx_burst_left = $urandom_range(20, 60);
      gap = 0;
    end else begin
      gap = $urandom_range(0, MAX_GAP);
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.source_byte  <= b;
    in_ch.end_of_input <= eoi;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    if (eoi) eoi_sent++;
    else bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  // Emit an optional separator, then a literal prefix; raw prefixes end in R.
  task automatic send_prefix(input bit raw);
    if ($urandom_range(0, 9) < 7) send_item(($urandom_range(0, 1) != 0) ? " " : ";", 1'b0);
    send_text(str_prefixes[$urandom_range(0, 4)]);
    if (raw) send_item(CH_UP_R, 1'b0);
  endtask

  // Result sink: random stalls, bursts with no stall, and one long hold-off on request.
  initial begin
    int unsigned gap;
    out_ch.ready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        results_held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        results_held = 1'b0;
      end
      if (rx_burst_left > 0) begin
        rx_burst_left--;
        gap = 0;
      end else if ($urandom_range(0, 19) == 0) begin
        rx_burst_left = $urandom_range(10, 40);
        gap = 0;
      end else begin
        gap = $urandom_range(0, MAX_GAP);
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  initial begin
    int unsigned tok;
    int unsigned n;
    int unsigned dlen;
    int unsigned drain_cycles;
    bit          cut;
    logic [7:0]  b;

    // Drive every block input to a known value from time zero.
    rst_ni             = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.source_byte  = '0;
    in_ch.end_of_input = 1'b0;
    hold_request       = 1'b0;
    results_held       = 1'b0;
    bytes_sent         = 0;
    eoi_sent           = 0;
    tx_burst_left      = 0;
    rx_burst_left      = 0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part.
    send_text("L\"x\"");              // prefixed string at offset zero
    send_text(" uR\"a(x)a\"");        // uR taken as a raw prefix
    send_text("/a");                  // lone slash opens nothing
    send_text("//c\n");               // line comment stops before the newline
    send_text("/**/");                // shortest block comment
    send_item(8'hFF, 1'b0);           // high bytes count as identifier bytes
    send_item(8'h00, 1'b0);
    send_text("u8\"");                // u8 prefix, then leave the string open ...
    send_item(8'hA5, 1'b1);           // ... end of input closes it at the total length
    send_item(8'h00, 1'b1);           // end of input with nothing open
    send_text("Lx");                  // failed prefix
    send_text("\"\\\"\"");            // escaped quote inside a string

    // Random part: mostly well-formed tokens with random content, some noise and
    // broken tokens. The sink holds off once early on.
    hold_request = 1'b1;
    while (bytes_sent + eoi_sent < RANDOM_ITEMS) begin
      tok = $urandom_range(0, 99);
      cut = ($urandom_range(0, 11) == 0);  // drop the closing sequence now and then
      if (tok < 12) begin
        // noise over the full byte range
        n = $urandom_range(1, 6);
        repeat (n) send_item(8'($urandom_range(0, 255)), 1'b0);
      end else if (tok < 20) begin
        // identifier run, so a following prefix without a separator is not recognized
        n = $urandom_range(1, 5);
        repeat (n) send_item(8'($urandom_range("a", "z")), 1'b0);
      end else if (tok < 40) begin
        // ordinary string with escapes and newlines
        send_prefix(1'b0);
        send_item(CH_DQUOTE, 1'b0);
        n = $urandom_range(0, 10);
        repeat (n) begin
          case ($urandom_range(0, 5))
            0: begin
              send_item(CH_BSLASH, 1'b0);
              send_item(8'($urandom_range(0, 255)), 1'b0);
            end
            1: send_item(CH_NL, 1'b0);
            default: begin
              do b = 8'($urandom_range(0, 255)); while (b == CH_DQUOTE || b == CH_BSLASH);
              send_item(b, 1'b0);
            end
          endcase
        end
        if (!cut) send_item(CH_DQUOTE, 1'b0);
      end else if (tok < 56) begin
        // raw string; some delimiters run past the stored length
        send_prefix(1'b1);
        send_item(CH_DQUOTE, 1'b0);
        dlen = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 4);
        for (int i = 0; i < dlen; i++) begin
          do b = 8'($urandom_range(0, 255)); while (b == CH_LPAREN);
          delim_bytes[i] = b;
          send_item(b, 1'b0);
        end
        send_item(CH_LPAREN, 1'b0);
        n = $urandom_range(0, 12);
        repeat (n) begin
          case ($urandom_range(0, 5))
            0: send_item(CH_RPAREN, 1'b0);
            1: send_item(CH_DQUOTE, 1'b0);
            2: send_item((dlen > 0) ? delim_bytes[$urandom_range(0, dlen - 1)] : CH_BSLASH,
                         1'b0);
            default: send_item(8'($urandom_range(0, 255)), 1'b0);
          endcase
        end
        if (!cut) begin
          // close on the truncated delimiter
          send_item(CH_RPAREN, 1'b0);
          for (int i = 0; i < dlen && i < MAX_DELIM_DEF; i++) send_item(delim_bytes[i], 1'b0);
          send_item(CH_DQUOTE, 1'b0);
        end
      end else if (tok < 66) begin
        // line comment
        send_text("//");
        n = $urandom_range(0, 8);
        repeat (n) begin
          do b = 8'($urandom_range(0, 255)); while (b == CH_NL);
          send_item(b, 1'b0);
        end
        if (!cut) send_item(CH_NL, 1'b0);
      end else if (tok < 78) begin
        // block comment with stray stars and slashes
        send_text("/*");
        n = $urandom_range(0, 8);
        repeat (n) begin
          case ($urandom_range(0, 3))
            0: send_item(CH_STAR, 1'b0);
            1: send_item(CH_SLASH, 1'b0);
            default: send_item(8'($urandom_range(0, 255)), 1'b0);
          endcase
        end
        if (!cut) send_text(($urandom_range(0, 1) != 0) ? "*/" : "**/");
      end else if (tok < 86) begin
        // lone slash or failed prefix
        case ($urandom_range(0, 2))
          0: send_text("/ ");
          1: send_text(" u8x");
          default: send_text(" LRa");
        endcase
      end else if (tok < 96) begin
        send_item(($urandom_range(0, 1) != 0) ? CH_NL : " ", 1'b0);
      end else begin
        // end of input, possibly in the middle of a span; the byte is ignored
        send_item(8'($urandom_range(0, 255)), 1'b1);
      end
    end
    in_ch.valid <= 1'b0;

    // Drain outstanding spans, then allow for the input and result registers of the block.
    drain_cycles = 0;
    while (pending_spans != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (10) @(posedge clk_i);

    if (pending_spans != 0) $display("%0d expected spans never arrived", pending_spans);
    $display("Sent %0d source bytes and %0d end markers through a %0d-cycle result hold-off",
             bytes_sent, eoi_sent, HOLD_CYCLES);
    $display("Checked %0d comment and %0d string spans of %0d predicted, %0d mismatches",
             comment_spans, string_spans, predicted_spans, fail_count);
    if (fail_count == 0 && pending_spans == 0) begin
      $display("cpp_comment_string_span_scanner test passed");
    end else begin
      $display("cpp_comment_string_span_scanner test failed");
    end
    $finish;
  end

endmodule
